// ===== hw/rtl/aegc_pkg.sv =====
// Shared types, constants and power table builder for the auto exposure gain controller.
`timescale 1ns / 1ps
`default_nettype none
package aegc_pkg;

  localparam int DIV_W  = 41;
  localparam int PROD_W = 65;
  localparam int TAB_N  = 256;
  localparam logic [63:0] PCAP = 64'd1 << 40;

  typedef logic [40:0] ptab_t [TAB_N];

  typedef enum logic [2:0] {
    REG_TARGET_MEAN      = 3'd0,
    REG_TOLERANCE        = 3'd1,
    REG_SETTLE_FRAMES    = 3'd2,
    REG_MAX_EXPOSURE     = 3'd3,
    REG_MIN_EXPOSURE     = 3'd4,
    REG_MAX_ANALOG_STEPS = 3'd5,
    REG_MAX_DIGITAL_GAIN = 3'd6,
    REG_MODE             = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [9:0]  target_mean;
    logic [9:0]  tolerance;
    logic [7:0]  settle_frames;
    logic [23:0] max_exposure;
    logic [23:0] min_exposure;
    logic [7:0]  max_analog_steps;
    logic [15:0] max_digital_gain;
    logic [1:0]  mode;
  } cfg_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_GX,
    OP_L_MUL1,
    OP_L_DIV1,
    OP_L_SET,
    OP_L_MUL2,
    OP_L_DIV2,
    OP_CUR_Q,
    OP_A_INIT,
    OP_A_RD,
    OP_A_MUL,
    OP_A_STEP,
    OP_A_UPD,
    OP_A_RD2,
    OP_A_FMUL,
    OP_A_FPOS,
    OP_A_FDIV,
    OP_GEND,
    OP_OEND,
    OP_OUT
  } op_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DISP,
    S_GCALL,
    S_L_MUL1,
    S_L_DIV1,
    S_L_WAIT1,
    S_L_SET,
    S_L_MUL2,
    S_L_DIV2,
    S_L_WAIT2,
    S_L_RES,
    S_A_INIT,
    S_A_CHK,
    S_A_RD,
    S_A_MUL,
    S_A_CMP,
    S_A_UPD,
    S_A_RD2,
    S_A_FMUL,
    S_A_FPOS,
    S_A_FDIV,
    S_A_FWAIT,
    S_A_FNEG,
    S_GEND,
    S_OEND,
    S_OUT
  } state_t;

  typedef enum logic [2:0] {
    PH_START,
    PH_EXP1,
    PH_GSTART,
    PH_GANA1,
    PH_GDIG1,
    PH_GLAST,
    PH_GRET,
    PH_EXP2
  } phase_t;

  typedef enum logic {
    RET_TOP,
    RET_EXP
  } ret_t;

  typedef struct packed {
    op_t  op;
    logic sel_dig;
    logic gclr;
    logic adj;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic t_gt_cur;
    logic off_cur;
    logic gcnt_zero;
    logic ocnt_zero;
    logic kk_lt_lim;
    logic cont;
    logic dneg;
    logic exp_on;
    logic dg_on;
  } status_t;

  function automatic ptab_t build_ptab();
    ptab_t       tab;
    logic [63:0] p;
    p = 64'd65536;
    for (int i = 0; i < TAB_N; i++) begin
      tab[i] = p[40:0];
      p = (p * 64'd118 + 64'd50) / 64'd100;
      if (p > PCAP) begin
        p = PCAP;
      end
    end
    return tab;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/aegc_cfg_regs.sv =====
// Configuration register bank with reset values.
`timescale 1ns / 1ps
`default_nettype none
module aegc_cfg_regs
  import aegc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [23:0] cfg_wdata,
  output cfg_t             cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.target_mean      <= 10'd128;
      cfg.tolerance        <= 10'd10;
      cfg.settle_frames    <= 8'd3;
      cfg.max_exposure     <= 24'd10000;
      cfg.min_exposure     <= 24'd1;
      cfg.max_analog_steps <= 8'd32;
      cfg.max_digital_gain <= 16'd4095;
      cfg.mode             <= 2'd3;
    end else if (cfg_wr_en) begin
      case (cfg_idx_t'(cfg_index))
        REG_TARGET_MEAN:      cfg.target_mean      <= cfg_wdata[9:0];
        REG_TOLERANCE:        cfg.tolerance        <= cfg_wdata[9:0];
        REG_SETTLE_FRAMES:    cfg.settle_frames    <= cfg_wdata[7:0];
        REG_MAX_EXPOSURE:     cfg.max_exposure     <= cfg_wdata;
        REG_MIN_EXPOSURE:     cfg.min_exposure     <= cfg_wdata;
        REG_MAX_ANALOG_STEPS: cfg.max_analog_steps <= cfg_wdata[7:0];
        REG_MAX_DIGITAL_GAIN: cfg.max_digital_gain <= cfg_wdata[15:0];
        REG_MODE:             cfg.mode             <= cfg_wdata[1:0];
        default: begin
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/aegc_div.sv =====
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module aegc_div
  import aegc_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [DIV_W-1:0] dividend,
  input  wire logic [DIV_W-1:0] divisor,
  output logic      [DIV_W-1:0] quotient,
  output logic                  done
);

  localparam int CW = $clog2(DIV_W + 1);

  logic [DIV_W:0]   rem;
  logic [DIV_W-1:0] den;
  logic [CW-1:0]    cnt;
  logic             busy;
  logic [DIV_W:0]   rem_sh;
  logic             fits;

  always_comb begin
    rem_sh = {rem[DIV_W-1:0], quotient[DIV_W-1]};
    fits   = rem_sh >= {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(DIV_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      den      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= fits ? (rem_sh - {1'b0, den}) : rem_sh;
      quotient <= {quotient[DIV_W-2:0], fits};
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/aegc_datapath.sv =====
// Settings, counters, multiplier, divider and power table of the controller.
`timescale 1ns / 1ps
`default_nettype none
module aegc_datapath
  import aegc_pkg::*;
#(
  parameter int MIN_ANALOG_STEP  = 0,
  parameter int POWER_TABLE_SIZE = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire cfg_t        cfg,
  input  wire cmd_t        cmd,
  input  wire logic [15:0] frame_mean,
  output status_t          status,
  output logic      [23:0] exposure_out,
  output logic      [7:0]  analog_step_out,
  output logic      [15:0] digital_gain_out,
  output logic      [15:0] expected_mean,
  output logic             adjusted
);

  localparam int    IW   = $clog2(POWER_TABLE_SIZE);
  localparam int    LIM  = POWER_TABLE_SIZE - 1;
  localparam ptab_t PTAB = build_ptab();

  logic [23:0] exp_r;
  logic [7:0]  ana_r;
  logic [15:0] dig_r;
  logic [8:0]  ocnt;
  logic [8:0]  gcnt;
  logic [15:0] m_r;
  logic [15:0] cur;
  logic [15:0] gx;
  logic [23:0] old_r;
  logic [23:0] nw_r;
  logic [PROD_W-1:0] prod;
  logic [40:0] ptab;
  logic [IW-1:0] kk;
  logic        dark;
  logic        dneg;

  logic [15:0] sm;
  logic [15:0] t16;
  logic [23:0] told;
  logic [15:0] mul_a;
  logic [40:0] mul_b;
  logic        mul_en;
  logic        div_start;
  logic [DIV_W-1:0] div_n;
  logic [DIV_W-1:0] div_d;
  logic [DIV_W-1:0] div_q;
  logic        div_done;
  logic [IW-1:0] tab_idx;
  logic [23:0] nw_c;
  logic [15:0] q_sat;
  logic [15:0] p_sat;
  logic [15:0] in_m;
  logic [8:0]  g_up;
  logic [8:0]  o_up;
  logic signed [10:0] a_old, a_fd, a_n, a_nc, a_delta, a_dcl, a_min, a_max, a_lim, a_mag;
  logic [10:0] kk11;

  function automatic logic off_target(input logic [15:0] x, input cfg_t c);
    logic [10:0] hi;
    logic [10:0] lo;
    hi = {1'b0, c.target_mean} + {1'b0, c.tolerance};
    lo = {1'b0, c.target_mean} - {1'b0, c.tolerance};
    if ({1'b0, x} > {hi, 6'b0}) begin
      return 1'b1;
    end
    if (c.target_mean >= c.tolerance && {1'b0, x} < {lo, 6'b0}) begin
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic [8:0] count_up(input logic [8:0] c);
    return (c != 9'd511) ? c + 9'd1 : c;
  endfunction

  aegc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_n),
    .divisor  (div_d),
    .quotient (div_q),
    .done     (div_done)
  );

  always_comb begin
    sm   = (cur == 16'd0) ? 16'd1 : cur;
    t16  = {cfg.target_mean, 6'b0};
    told = (old_r == 24'd0) ? 24'd1 : old_r;
    in_m = (frame_mean == 16'd0) ? 16'd1 : frame_mean;

    mul_en = 1'b1;
    mul_a  = '0;
    mul_b  = '0;
    case (cmd.op)
      OP_L_MUL1: begin
        mul_a = t16;
        mul_b = cmd.sel_dig ? {25'b0, dig_r} : {17'b0, exp_r};
      end
      OP_L_MUL2: begin
        mul_a = sm;
        mul_b = {17'b0, nw_r};
      end
      OP_A_MUL: begin
        mul_a = dark ? sm : t16;
        mul_b = ptab;
      end
      OP_A_FMUL: begin
        mul_a = sm;
        mul_b = ptab;
      end
      default: mul_en = 1'b0;
    endcase

    div_start = 1'b1;
    div_n     = prod[DIV_W-1:0];
    div_d     = {25'b0, sm};
    case (cmd.op)
      OP_L_DIV1: div_d = {25'b0, sm};
      OP_L_DIV2: div_d = {17'b0, told};
      OP_A_FDIV: begin
        div_n = {9'b0, sm, 16'b0};
        div_d = ptab;
      end
      default: div_start = 1'b0;
    endcase

    tab_idx = (cmd.op == OP_A_RD && dark) ? kk + 1'b1 : kk;

    if (cmd.sel_dig) begin
      if (div_q <= 41'd256) begin
        nw_c = 24'd256;
      end else if (div_q > {25'b0, cfg.max_digital_gain}) begin
        nw_c = {8'b0, cfg.max_digital_gain};
      end else begin
        nw_c = {8'b0, div_q[15:0]};
      end
    end else begin
      if (div_q < {17'b0, cfg.min_exposure}) begin
        nw_c = cfg.min_exposure;
      end else if (div_q > {17'b0, cfg.max_exposure}) begin
        nw_c = cfg.max_exposure;
      end else begin
        nw_c = div_q[23:0];
      end
    end

    q_sat = (div_q > 41'd65535) ? 16'hFFFF : div_q[15:0];
    p_sat = (prod[PROD_W-1:16] > 49'd65535) ? 16'hFFFF : prod[31:16];

    kk11  = 11'(kk);
    a_old = $signed({3'b0, ana_r});
    a_fd  = dark ? $signed(kk11) : -$signed(kk11);
    a_min = $signed(11'(MIN_ANALOG_STEP));
    a_max = $signed({3'b0, cfg.max_analog_steps});
    a_lim = $signed(11'(LIM));
    a_n   = a_old + a_fd;
    if (a_n < a_min) begin
      a_nc = a_min;
    end else if (a_n > a_max) begin
      a_nc = a_max;
    end else begin
      a_nc = a_n;
    end
    a_delta = a_nc - a_old;
    if (a_delta > a_lim) begin
      a_dcl = a_lim;
    end else if (a_delta < -a_lim) begin
      a_dcl = -a_lim;
    end else begin
      a_dcl = a_delta;
    end
    a_mag = (a_dcl < 0) ? -a_dcl : a_dcl;

    g_up = (gcnt == 9'd0) ? 9'd2 : count_up(gcnt);
    o_up = (ocnt == 9'd0) ? 9'd2 : count_up(ocnt);

    status.div_done  = div_done;
    status.t_gt_cur  = t16 > cur;
    status.off_cur   = off_target(cur, cfg);
    status.gcnt_zero = gcnt == 9'd0;
    status.ocnt_zero = ocnt == 9'd0;
    status.kk_lt_lim = kk < IW'(LIM);
    status.cont      = dark ? (prod <= {33'b0, t16, 16'b0})
                            : (prod < {33'b0, sm, 16'b0});
    status.dneg      = dneg;
    status.exp_on    = cfg.mode[0];
    status.dg_on     = cfg.mode[1];
  end

  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod <= mul_a * mul_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      exp_r <= 24'd1000;
      ana_r <= 8'd0;
      dig_r <= 16'd256;
      ocnt  <= 9'd0;
      gcnt  <= 9'd0;
    end else begin
      case (cmd.op)
        OP_GX: begin
          if (cmd.gclr) begin
            gcnt <= 9'd0;
          end
        end
        OP_L_SET: begin
          if (cmd.sel_dig) begin
            dig_r <= nw_c[15:0];
          end else begin
            exp_r <= nw_c;
          end
        end
        OP_A_UPD: ana_r <= a_nc[7:0];
        OP_GEND:  gcnt  <= (g_up > {1'b0, cfg.settle_frames} && off_target(gx, cfg))
                           ? 9'd0 : g_up;
        OP_OEND:  ocnt  <= (o_up > {1'b0, cfg.settle_frames} && off_target(m_r, cfg))
                           ? 9'd0 : o_up;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        m_r <= in_m;
        cur <= in_m;
      end
      OP_GX:    gx <= cur;
      OP_L_SET: begin
        nw_r  <= nw_c;
        old_r <= cmd.sel_dig ? {8'b0, dig_r} : exp_r;
      end
      OP_CUR_Q:  cur <= q_sat;
      OP_A_INIT: begin
        dark <= sm <= t16;
        kk   <= (sm <= t16) ? IW'(0) : IW'(1);
      end
      OP_A_RD:   ptab <= PTAB[8'(tab_idx)];
      OP_A_STEP: kk <= kk + 1'b1;
      OP_A_UPD: begin
        kk   <= IW'(unsigned'(a_mag));
        dneg <= a_dcl < 0;
      end
      OP_A_RD2:  ptab <= PTAB[8'(kk)];
      OP_A_FPOS: cur <= p_sat;
      OP_OUT: begin
        exposure_out     <= exp_r;
        analog_step_out  <= ana_r;
        digital_gain_out <= dig_r;
        expected_mean    <= cur;
        adjusted         <= cmd.adj;
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== hw/rtl/aegc_ctrl.sv =====
// Sequencing state machine for the correction stages.
`timescale 1ns / 1ps
`default_nettype none
module aegc_ctrl
  import aegc_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_ready,
  output logic         out_valid,
  input  wire logic    out_ready,
  input  wire status_t status,
  output cmd_t         cmd
);

  state_t state, state_next;
  phase_t phase, phase_next;
  ret_t   gret, gret_next;
  logic   sel_dig, sel_dig_next;
  logic   gclr, gclr_next;
  logic   adj, adj_next;
  logic   out_set;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      phase     <= PH_START;
      gret      <= RET_TOP;
      sel_dig   <= 1'b0;
      gclr      <= 1'b0;
      adj       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      phase   <= phase_next;
      gret    <= gret_next;
      sel_dig <= sel_dig_next;
      gclr    <= gclr_next;
      adj     <= adj_next;
      if (out_set) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next   = state;
    phase_next   = phase;
    gret_next    = gret;
    sel_dig_next = sel_dig;
    gclr_next    = gclr;
    adj_next     = adj;
    out_set      = 1'b0;
    in_ready     = 1'b0;
    cmd.op       = OP_NONE;
    cmd.sel_dig  = sel_dig;
    cmd.gclr     = gclr;
    cmd.adj      = adj;

    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op     = OP_LOAD;
          phase_next = PH_START;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        case (phase)
          PH_START: begin
            if (status.exp_on) begin
              adj_next = status.ocnt_zero;
              if (!status.ocnt_zero) begin
                state_next = S_OEND;
              end else if (status.t_gt_cur) begin
                sel_dig_next = 1'b0;
                phase_next   = PH_EXP1;
                state_next   = S_L_MUL1;
              end else begin
                gclr_next  = 1'b1;
                gret_next  = RET_EXP;
                state_next = S_GCALL;
              end
            end else begin
              adj_next   = status.gcnt_zero;
              gclr_next  = 1'b0;
              gret_next  = RET_TOP;
              state_next = S_GCALL;
            end
          end
          PH_EXP1: begin
            if (status.off_cur) begin
              gclr_next  = 1'b1;
              gret_next  = RET_TOP;
              state_next = S_GCALL;
            end else begin
              state_next = status.exp_on ? S_OEND : S_OUT;
            end
          end
          PH_GSTART: begin
            if (!status.gcnt_zero) begin
              state_next = S_GEND;
            end else if (status.t_gt_cur) begin
              phase_next = PH_GANA1;
              state_next = S_A_INIT;
            end else if (status.dg_on) begin
              sel_dig_next = 1'b1;
              phase_next   = PH_GDIG1;
              state_next   = S_L_MUL1;
            end else begin
              phase_next = PH_GLAST;
              state_next = S_A_INIT;
            end
          end
          PH_GANA1: begin
            if (status.off_cur && status.dg_on) begin
              sel_dig_next = 1'b1;
              phase_next   = PH_GLAST;
              state_next   = S_L_MUL1;
            end else begin
              state_next = S_GEND;
            end
          end
          PH_GDIG1: begin
            if (status.off_cur) begin
              phase_next = PH_GLAST;
              state_next = S_A_INIT;
            end else begin
              state_next = S_GEND;
            end
          end
          PH_GLAST: state_next = S_GEND;
          PH_GRET: begin
            if (gret == RET_EXP && status.off_cur) begin
              sel_dig_next = 1'b0;
              phase_next   = PH_EXP2;
              state_next   = S_L_MUL1;
            end else begin
              state_next = status.exp_on ? S_OEND : S_OUT;
            end
          end
          PH_EXP2: state_next = status.exp_on ? S_OEND : S_OUT;
          default: state_next = S_OUT;
        endcase
      end
      S_GCALL: begin
        cmd.op     = OP_GX;
        phase_next = PH_GSTART;
        state_next = S_DISP;
      end
      S_L_MUL1: begin
        cmd.op     = OP_L_MUL1;
        state_next = S_L_DIV1;
      end
      S_L_DIV1: begin
        cmd.op     = OP_L_DIV1;
        state_next = S_L_WAIT1;
      end
      S_L_WAIT1: begin
        if (status.div_done) begin
          state_next = S_L_SET;
        end
      end
      S_L_SET: begin
        cmd.op     = OP_L_SET;
        state_next = S_L_MUL2;
      end
      S_L_MUL2: begin
        cmd.op     = OP_L_MUL2;
        state_next = S_L_DIV2;
      end
      S_L_DIV2: begin
        cmd.op     = OP_L_DIV2;
        state_next = S_L_WAIT2;
      end
      S_L_WAIT2: begin
        if (status.div_done) begin
          state_next = S_L_RES;
        end
      end
      S_L_RES: begin
        cmd.op     = OP_CUR_Q;
        state_next = S_DISP;
      end
      S_A_INIT: begin
        cmd.op     = OP_A_INIT;
        state_next = S_A_CHK;
      end
      S_A_CHK: state_next = status.kk_lt_lim ? S_A_RD : S_A_UPD;
      S_A_RD: begin
        cmd.op     = OP_A_RD;
        state_next = S_A_MUL;
      end
      S_A_MUL: begin
        cmd.op     = OP_A_MUL;
        state_next = S_A_CMP;
      end
      S_A_CMP: begin
        if (status.cont) begin
          cmd.op     = OP_A_STEP;
          state_next = S_A_CHK;
        end else begin
          state_next = S_A_UPD;
        end
      end
      S_A_UPD: begin
        cmd.op     = OP_A_UPD;
        state_next = S_A_RD2;
      end
      S_A_RD2: begin
        cmd.op     = OP_A_RD2;
        state_next = status.dneg ? S_A_FDIV : S_A_FMUL;
      end
      S_A_FMUL: begin
        cmd.op     = OP_A_FMUL;
        state_next = S_A_FPOS;
      end
      S_A_FPOS: begin
        cmd.op     = OP_A_FPOS;
        state_next = S_DISP;
      end
      S_A_FDIV: begin
        cmd.op     = OP_A_FDIV;
        state_next = S_A_FWAIT;
      end
      S_A_FWAIT: begin
        if (status.div_done) begin
          state_next = S_A_FNEG;
        end
      end
      S_A_FNEG: begin
        cmd.op     = OP_CUR_Q;
        state_next = S_DISP;
      end
      S_GEND: begin
        cmd.op     = OP_GEND;
        phase_next = PH_GRET;
        state_next = S_DISP;
      end
      S_OEND: begin
        cmd.op     = OP_OEND;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (!out_valid || out_ready) begin
          cmd.op     = OP_OUT;
          out_set    = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ===== hw/rtl/auto_exposure_gain_controller_top.sv =====
// Top level of the auto exposure and gain controller.
//
// One frame mean (unsigned Q10.6) is taken per transfer on the input channel
// (in_valid / in_ready); one result per frame leaves on the output channel
// (out_valid / out_ready) with the exposure, analog step and digital gain now
// in force, the predicted mean and the adjusted flag.
// Registers are written by the user through cfg_wr_en / cfg_index / cfg_wdata
// only while idle; the block itself does not enforce this. When the outer
// frame counter is busy, nothing is recomputed; else each exposure or digital
// gain stage makes two passes through the restoring divider; the analog stage
// searches the power table step by step, plus one divide for a downward move.
// One frame is processed at a time; the next transfer is taken once the
// result sits in the output register.
// If the receiver stalls, the finished result holds in the output register,
// and a following frame runs until its own result is ready, then waits.
// Synchronous reset restores the register defaults, exposure 1000, analog
// step 0, digital gain 256 and clears both frame counters.
`timescale 1ns / 1ps
`default_nettype none
module auto_exposure_gain_controller_top
  import aegc_pkg::*;
#(
  parameter int MIN_ANALOG_STEP  = 0,
  parameter int POWER_TABLE_SIZE = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [23:0] cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [15:0] frame_mean,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic      [23:0] exposure_out,
  output logic      [7:0]  analog_step_out,
  output logic      [15:0] digital_gain_out,
  output logic      [15:0] expected_mean,
  output logic             adjusted
);

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;

  aegc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  aegc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  aegc_datapath #(
    .MIN_ANALOG_STEP  (MIN_ANALOG_STEP),
    .POWER_TABLE_SIZE (POWER_TABLE_SIZE)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cfg              (cfg),
    .cmd              (cmd),
    .frame_mean       (frame_mean),
    .status           (status),
    .exposure_out     (exposure_out),
    .analog_step_out  (analog_step_out),
    .digital_gain_out (digital_gain_out),
    .expected_mean    (expected_mean),
    .adjusted         (adjusted)
  );

endmodule
`default_nettype wire
